// ----- sv/ale_pkg.sv -----
`timescale 1ns / 1ps
// ale_pkg: field widths, command and status codes, compare result type.
// No dependencies; used by every module of the array list engine.
package ale_pkg;

    localparam int ACT_W = 4;
    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int ST_W  = 3;
    localparam int FP_W  = 7;
    localparam int CNT_W = 7;

    localparam logic [ACT_W-1:0] ACT_APPEND  = 4'd0;
    localparam logic [ACT_W-1:0] ACT_INS_POS = 4'd1;
    localparam logic [ACT_W-1:0] ACT_DEL_POS = 4'd2;
    localparam logic [ACT_W-1:0] ACT_INS_KEY = 4'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_KEY = 4'd4;
    localparam logic [ACT_W-1:0] ACT_ORD_INS = 4'd5;
    localparam logic [ACT_W-1:0] ACT_SEARCH  = 4'd6;
    localparam logic [ACT_W-1:0] ACT_RD_POS  = 4'd7;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_DUMP    = 4'd9;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_PRESENT  = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic eq;   // a == b
        logic gt;   // a > b, signed
    } t_cmp_res;

endpackage

// ----- sv/array_list_engine.sv -----
`timescale 1ns / 1ps
// array_list_engine: packed list of signed words under a command sequencer.
// Depends on ale_pkg, ale_store (element memory) and ale_cmp (compare unit).
//
//  channel | valid   | stall   | beat payload
//  --------+---------+---------+-------------------------------------------------
//  command | i_valid | o_stall | i_action, i_value, i_position
//  result  | o_valid | i_stall | o_status, o_found_position, o_data, o_count, o_last
//
// Datapath: every command runs through one memory port pair and one compare unit.
// A key scan spends a read and a compare state per element visited, a shift a read
// and a write state per element moved, plus setup and result states; append writes
// the value with no shift, a positional insert or delete shifts the list from the
// position on, and a key insert that misses scans, then shifts the whole list. A
// reverse dump runs fetch, load and out per beat, as the memory read is registered.
// Reset: synchronous, active low; clears r_state, r_count, r_k, r_dump, r_last,
// r_status and r_fp; the memory holds garbage until written. o_stall is high while
// a command is in work; a stalled result beat holds and the sequencer waits on it.
module array_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [ale_pkg::ACT_W-1:0] i_action,
    input  logic signed [ale_pkg::VAL_W-1:0] i_value,
    input  logic [ale_pkg::POS_W-1:0] i_position,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ale_pkg::ST_W-1:0]  o_status,
    output logic [ale_pkg::FP_W-1:0]  o_found_position,
    output logic signed [ale_pkg::VAL_W-1:0] o_data,
    output logic [ale_pkg::CNT_W-1:0] o_count,
    output logic                      o_last
);
    import ale_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,   // issue read of element r_k, or finish a miss
        S_SCAN_CMP,  // compare element r_k against the key
        S_UP_RD,     // insert: read r_k-1 for the upward shift
        S_UP_WR,     // insert: write it to r_k
        S_PUT,       // insert: drop the value into the hole
        S_DN_RD,     // remove: read r_k+1
        S_DN_WR,     // remove: write it to r_k
        S_FETCH,     // read for read-position and dump
        S_LOAD,      // latch read data into the result
        S_OUT        // result beat on the port
    } t_state;

    t_state r_state;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_k;
    logic [AW-1:0]    r_idx;
    logic [ACT_W-1:0] r_action;
    logic [VAL_W-1:0] r_value;
    logic             r_dump;
    logic [ST_W-1:0]  r_status;
    logic [FP_W-1:0]  r_fp;
    logic [VAL_W-1:0] r_data;
    logic             r_last;

    logic [CW-1:0]    k_dec;
    logic [CW-1:0]    k_inc;
    logic             full;
    logic             pos_ok;
    logic             accept;
    logic             out_take;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;
    t_cmp_res         cmp;

    ale_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // the one compare unit: stored element against the latched key
    ale_cmp u_cmp (
        .i_a   (mem_rdata),
        .i_b   (r_value),
        .o_res (cmp)
    );

    assign k_dec    = r_k - CW'(1);
    assign k_inc    = r_k + CW'(1);
    assign full     = (r_count == CW'(CAPACITY));
    // position is 1-based and must land inside the current list
    assign pos_ok   = (i_position != '0) && (i_position <= POS_W'(r_count));
    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign o_valid  = (r_state == S_OUT);
    assign out_take = o_valid && !i_stall;

    assign o_status         = r_status;
    assign o_found_position = r_fp;
    assign o_data           = r_data;
    assign o_count          = CNT_W'(r_count);
    assign o_last           = r_last;

    // memory port steering from the sequencer state
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_k[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_k[AW-1:0];
        case (r_state)
            S_UP_RD: mem_raddr = k_dec[AW-1:0];
            S_DN_RD: mem_raddr = k_inc[AW-1:0];
            S_UP_WR: mem_we = 1'b1;
            S_DN_WR: mem_we = 1'b1;
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_value;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_k      <= '0;
            r_dump   <= 1'b0;
            r_last   <= 1'b0;
            r_status <= ST_OK;
            r_fp     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_action <= i_action;
                        r_value  <= i_value;
                        r_status <= ST_OK;
                        r_fp     <= '0;
                        r_data   <= '0;
                        r_last   <= 1'b1;
                        r_dump   <= 1'b0;
                        r_k      <= r_count;
                        unique case (i_action) inside
                            ACT_APPEND: begin
                                if (full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_idx   <= r_count[AW-1:0];
                                    r_state <= S_UP_RD;
                                end
                            end
                            ACT_INS_POS: begin
                                // bad position wins over a full list
                                if (!pos_ok) begin
                                    r_status <= ST_BADPOS;
                                    r_state  <= S_OUT;
                                end else if (full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_idx   <= AW'(i_position - POS_W'(1));
                                    r_state <= S_UP_RD;
                                end
                            end
                            ACT_DEL_POS: begin
                                if (!pos_ok) begin
                                    r_status <= ST_BADPOS;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_k     <= CW'(i_position - POS_W'(1));
                                    r_state <= S_DN_RD;
                                end
                            end
                            ACT_INS_KEY, ACT_DEL_KEY, ACT_SEARCH: begin
                                r_k     <= '0;
                                r_state <= S_SCAN_RD;
                            end
                            ACT_ORD_INS: begin
                                if (full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_k     <= '0;
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            ACT_RD_POS: begin
                                if (!pos_ok) begin
                                    r_status <= ST_BADPOS;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_k     <= CW'(i_position - POS_W'(1));
                                    r_state <= S_FETCH;
                                end
                            end
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_OUT;
                            end
                            ACT_DUMP: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_dump  <= 1'b1;
                                    r_k     <= r_count - CW'(1);
                                    r_state <= S_FETCH;
                                end
                            end
                            default: r_state <= S_OUT;  // unused codes: no-op
                        endcase
                    end
                end

                S_SCAN_RD: begin
                    if (r_k == r_count) begin
                        // ran off the end without a hit
                        unique case (r_action) inside
                            ACT_INS_KEY: begin
                                if (full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= S_UP_RD;
                                end
                            end
                            ACT_ORD_INS: begin
                                r_idx   <= r_count[AW-1:0];
                                r_state <= S_UP_RD;
                            end
                            default: begin
                                r_status <= ST_NOTFOUND;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end else begin
                        r_state <= S_SCAN_CMP;
                    end
                end

                S_SCAN_CMP: begin
                    if (r_action == ACT_ORD_INS) begin
                        // first strictly larger element: place before it
                        if (cmp.gt) begin
                            r_idx   <= r_k[AW-1:0];
                            r_k     <= r_count;
                            r_state <= S_UP_RD;
                        end else begin
                            r_k     <= k_inc;
                            r_state <= S_SCAN_RD;
                        end
                    end else if (cmp.eq) begin
                        r_fp <= FP_W'(r_k) + FP_W'(1);
                        unique case (r_action) inside
                            ACT_INS_KEY: begin
                                r_status <= ST_PRESENT;
                                r_state  <= S_OUT;
                            end
                            ACT_DEL_KEY: r_state <= S_DN_RD;
                            default: begin
                                r_data  <= r_value;
                                r_state <= S_OUT;
                            end
                        endcase
                    end else begin
                        r_k     <= k_inc;
                        r_state <= S_SCAN_RD;
                    end
                end

                S_UP_RD: begin
                    if (r_k == CW'(r_idx)) begin
                        r_state <= S_PUT;
                    end else begin
                        r_state <= S_UP_WR;
                    end
                end

                S_UP_WR: begin
                    r_k     <= k_dec;
                    r_state <= S_UP_RD;
                end

                S_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_OUT;
                end

                S_DN_RD: begin
                    // stop once r_k is the last element
                    if ({1'b0, k_inc} >= {1'b0, r_count}) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DN_WR;
                    end
                end

                S_DN_WR: begin
                    r_k     <= k_inc;
                    r_state <= S_DN_RD;
                end

                S_FETCH: r_state <= S_LOAD;

                S_LOAD: begin
                    r_data  <= mem_rdata;
                    r_last  <= !r_dump || (r_k == '0);
                    r_state <= S_OUT;
                end

                S_OUT: begin
                    if (out_take) begin
                        if (r_dump && !r_last) begin
                            r_k     <= k_dec;
                            r_state <= S_FETCH;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/ale_store.sv -----
`timescale 1ns / 1ps
// ale_store: element memory, one write port, one read port, registered read data.
// Depends on ale_pkg for the word width.
module ale_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ale_pkg::VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [ale_pkg::VAL_W-1:0] o_rdata
);
    import ale_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ale_cmp.sv -----
`timescale 1ns / 1ps
// ale_cmp: shared compare unit, equality and signed greater-than on one word pair.
// Depends on ale_pkg for the word width and the result struct.
module ale_cmp (
    input  logic [ale_pkg::VAL_W-1:0] i_a,
    input  logic [ale_pkg::VAL_W-1:0] i_b,
    output ale_pkg::t_cmp_res         o_res
);
    import ale_pkg::*;

    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.gt = ($signed(i_a) > $signed(i_b));
    end

endmodule
